### hdl/stop_and_wait_sender_assert.svh
// Assertion macros for the stop-and-wait sender.
// Included inside module bodies; expects clk_i and rst_ni in scope.
`ifndef STOP_AND_WAIT_SENDER_ASSERT_SVH
`define STOP_AND_WAIT_SENDER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SWS_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/sws_pkg.sv
// Package for the stop-and-wait sender: transaction structs, codes and the header checksum.
// Depends on nothing; used by stop_and_wait_sender.
package sws_pkg;

  localparam int unsigned SegmentBytesDflt = 1024;
  localparam logic [15:0] TimeoutReset     = 16'd500;

  typedef enum logic [2:0] {
    FN_TICK  = 3'd0,
    FN_OPEN  = 3'd1,
    FN_START = 3'd2,
    FN_CLOSE = 3'd3,
    FN_RX    = 3'd4
  } func_e;

  localparam logic [2:0] FL_DATA    = 3'd0;
  localparam logic [2:0] FL_SYN     = 3'd1;
  localparam logic [2:0] FL_ACK     = 3'd2;
  localparam logic [2:0] FL_SYN_ACK = 3'd3;
  localparam logic [2:0] FL_FIN     = 3'd4;
  localparam logic [2:0] FL_FIN_ACK = 3'd6;
  localparam logic [2:0] FL_OVER    = 3'd7;

  typedef enum logic [3:0] {
    PH_CLOSED      = 4'd0,
    PH_SYN_SENT    = 4'd1,
    PH_READY       = 4'd2,
    PH_WAIT_ACK    = 4'd3,
    PH_WAIT_OVER   = 4'd4,
    PH_FIN_WAIT    = 4'd5,
    PH_WAIT_FINACK = 4'd6,
    PH_TIME_WAIT   = 4'd7,
    PH_FAILED      = 4'd8
  } phase_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] total_len;
    logic [15:0] rx_checksum;
    logic [15:0] rx_index;
    logic [31:0] rx_filelen;
    logic [7:0]  rx_flag;
  } sws_in_t;

  typedef struct packed {
    logic        send_valid;
    logic [2:0]  tx_flag;
    logic [15:0] tx_index;
    logic [31:0] tx_filelen;
    logic [15:0] tx_checksum;
    logic [31:0] payload_offset;
    logic [10:0] payload_len;
    logic [3:0]  phase;
  } sws_out_t;

  // One's complement sum of the six header words with end-around carry, complemented.
  function automatic logic [15:0] hdr_csum(input logic [15:0] csum, input logic [15:0] idx,
                                           input logic [31:0] flen, input logic [7:0] flag);
    logic [15:0] w [6];
    logic [16:0] s;
    w[0] = csum;
    w[1] = idx;
    w[2] = flen[15:0];
    w[3] = flen[31:16];
    w[4] = {8'd0, flag};
    w[5] = 16'd0;
    s = 17'd0;
    for (int i = 0; i < 6; i++) begin
      s = {1'b0, s[15:0]} + {1'b0, w[i]};
      if (s[16]) begin
        s = {1'b0, s[15:0]} + 17'd1;
      end
    end
    return ~s[15:0];
  endfunction

endpackage

### hdl/stop_and_wait_sender.sv
// Usage: the input channel (in_valid_i, in_ready_o, in_data_i) carries one event per
// transaction: a timer tick, open, start of a transfer, close, or a received header.
// The output channel (out_valid_o, out_ready_i, out_data_o) returns exactly one result
// transaction per event, telling whether a header goes out now, its fields, the payload
// window of a data segment and the link phase after the event.
// The result is registered: the result of an event accepted at one edge is valid after that edge.
// Throughput is one event per cycle; the event logic and checksum sit between the state
// registers and a single output register, so a new event is taken whenever the output
// register is empty or is being emptied in the same cycle.
// When the receiver stalls, the result stays in the output register and in_ready_o drops
// until it is taken; no event is lost or duplicated.
// Reset clears the link to the closed phase, all counters and held header to zero, and
// the timeout register to 500 ticks. cfg_we_i writes the timeout in any cycle, without
// handshake, and is meant to be used while the block is idle.
// This file depends on sws_pkg and stop_and_wait_sender_assert.svh.
module stop_and_wait_sender #(
  parameter int unsigned SEGMENT_BYTES = sws_pkg::SegmentBytesDflt
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  sws_pkg::sws_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output sws_pkg::sws_out_t out_data_o,
  input  logic             cfg_we_i,
  input  logic [15:0]      cfg_data_i
);
  import sws_pkg::*;

  localparam logic [10:0] SegLen = 11'(SEGMENT_BYTES);

  typedef enum logic [2:0] {
    EM_NONE,
    EM_CTRL,
    EM_SEG,
    EM_ECHO,
    EM_HELD
  } emit_e;

  logic [15:0] timeout_q;
  phase_e      phase_q, phase_d;
  logic [15:0] seq_q, seq_d;
  logic [15:0] timer_q, timer_d;
  logic [31:0] left_q, left_d;
  logic [31:0] off_q, off_d;
  logic [2:0]  held_flag_q, held_flag_d;
  logic [31:0] held_filelen_q, held_filelen_d;
  logic [15:0] held_csum_q, held_csum_d;
  logic [10:0] held_seg_len_q, held_seg_len_d;

  logic        out_valid_q;
  sws_out_t    out_q, res_d;

  logic        in_fire;
  func_e       func;
  logic        rx_ok;
  logic [15:0] timer_inc;
  logic [31:0] adv_off, adv_left;
  logic [15:0] adv_seq;
  logic [31:0] seg_left, seg_off;
  logic [15:0] seg_idx;
  logic [10:0] seg_len;
  logic [15:0] seg_csum;
  logic [2:0]  ctrl_flag;
  logic [15:0] ctrl_csum;
  logic [15:0] echo_csum;
  emit_e       emit;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign func      = func_e'(in_data_i.func);
  assign rx_ok     = hdr_csum(in_data_i.rx_checksum, in_data_i.rx_index,
                              in_data_i.rx_filelen, in_data_i.rx_flag) == 16'd0;
  assign timer_inc = timer_q + 16'd1;

  assign adv_off  = off_q + 32'(held_seg_len_q);
  assign adv_left = left_q - 32'(held_seg_len_q);
  assign adv_seq  = seq_q + 16'd1;

  assign seg_left = (func == FN_START) ? in_data_i.total_len : adv_left;
  assign seg_off  = (func == FN_START) ? 32'd0 : adv_off;
  assign seg_idx  = (func == FN_START) ? 16'd0 : adv_seq;
  assign seg_len  = (seg_left < 32'(SEGMENT_BYTES)) ? seg_left[10:0] : SegLen;
  assign seg_csum = hdr_csum(16'd0, seg_idx, 32'(seg_len), 8'd0);

  always_comb begin
    unique case (func)
      FN_OPEN:  ctrl_flag = FL_SYN;
      FN_CLOSE: ctrl_flag = FL_FIN;
      default:  ctrl_flag = FL_OVER;
    endcase
  end

  assign ctrl_csum = hdr_csum(16'd0, 16'd0, 32'd0, 8'(ctrl_flag));
  assign echo_csum = hdr_csum(16'd0, in_data_i.rx_index, in_data_i.rx_filelen, 8'(FL_ACK));

  always_comb begin
    phase_d        = phase_q;
    seq_d          = seq_q;
    timer_d        = timer_q;
    left_d         = left_q;
    off_d          = off_q;
    held_flag_d    = held_flag_q;
    held_filelen_d = held_filelen_q;
    held_csum_d    = held_csum_q;
    held_seg_len_d = held_seg_len_q;
    emit           = EM_NONE;

    if (in_fire) begin
      unique case (func)
        FN_TICK: begin
          if (phase_q == PH_SYN_SENT || phase_q == PH_WAIT_ACK || phase_q == PH_WAIT_OVER ||
              phase_q == PH_FIN_WAIT || phase_q == PH_TIME_WAIT) begin
            timer_d = timer_inc;
            if (timer_inc >= timeout_q) begin
              timer_d = 16'd0;
              if (phase_q == PH_TIME_WAIT) begin
                phase_d = PH_CLOSED;
              end else begin
                emit = EM_HELD;
              end
            end
          end
        end
        FN_OPEN: begin
          if (phase_q == PH_CLOSED || phase_q == PH_FAILED) begin
            emit    = EM_CTRL;
            phase_d = PH_SYN_SENT;
          end
        end
        FN_START: begin
          if (phase_q == PH_READY) begin
            seq_d  = 16'd0;
            off_d  = 32'd0;
            left_d = in_data_i.total_len;
            if (in_data_i.total_len == 32'd0) begin
              emit    = EM_CTRL;
              phase_d = PH_WAIT_OVER;
            end else begin
              emit    = EM_SEG;
              phase_d = PH_WAIT_ACK;
            end
          end
        end
        FN_CLOSE: begin
          if (phase_q == PH_READY) begin
            emit    = EM_CTRL;
            phase_d = PH_FIN_WAIT;
          end
        end
        FN_RX: begin
          unique case (phase_q)
            PH_SYN_SENT: begin
              if (rx_ok && in_data_i.rx_flag == 8'(FL_SYN_ACK)) begin
                emit    = EM_ECHO;
                phase_d = PH_READY;
              end else begin
                phase_d = PH_FAILED;
              end
            end
            PH_WAIT_ACK: begin
              if (rx_ok && in_data_i.rx_flag == 8'(FL_ACK) && in_data_i.rx_index == seq_q) begin
                off_d  = adv_off;
                left_d = adv_left;
                seq_d  = adv_seq;
                if (adv_left != 32'd0) begin
                  emit = EM_SEG;
                end else begin
                  emit    = EM_CTRL;
                  phase_d = PH_WAIT_OVER;
                end
              end
            end
            PH_WAIT_OVER: begin
              if (rx_ok && in_data_i.rx_flag == 8'(FL_OVER)) begin
                timer_d = 16'd0;
                phase_d = PH_READY;
              end
            end
            PH_FIN_WAIT: begin
              timer_d = 16'd0;
              phase_d = (rx_ok && in_data_i.rx_flag == 8'(FL_ACK)) ? PH_WAIT_FINACK : PH_FAILED;
            end
            PH_WAIT_FINACK: begin
              if (rx_ok && in_data_i.rx_flag == 8'(FL_FIN_ACK)) begin
                emit    = EM_ECHO;
                timer_d = 16'd0;
                phase_d = PH_TIME_WAIT;
              end
            end
            PH_TIME_WAIT: begin
              emit    = EM_ECHO;
              timer_d = 16'd0;
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end

    res_d = '0;
    unique case (emit)
      EM_CTRL: begin
        held_flag_d       = ctrl_flag;
        held_filelen_d    = 32'd0;
        held_csum_d       = ctrl_csum;
        held_seg_len_d    = 11'd0;
        timer_d           = 16'd0;
        res_d.send_valid  = 1'b1;
        res_d.tx_flag     = ctrl_flag;
        res_d.tx_checksum = ctrl_csum;
      end
      EM_SEG: begin
        held_flag_d          = FL_DATA;
        held_filelen_d       = 32'(seg_len);
        held_csum_d          = seg_csum;
        held_seg_len_d       = seg_len;
        timer_d              = 16'd0;
        res_d.send_valid     = 1'b1;
        res_d.tx_flag        = FL_DATA;
        res_d.tx_index       = seg_idx;
        res_d.tx_filelen     = 32'(seg_len);
        res_d.tx_checksum    = seg_csum;
        res_d.payload_offset = seg_off;
        res_d.payload_len    = seg_len;
      end
      EM_ECHO: begin
        res_d.send_valid  = 1'b1;
        res_d.tx_flag     = FL_ACK;
        res_d.tx_index    = in_data_i.rx_index;
        res_d.tx_filelen  = in_data_i.rx_filelen;
        res_d.tx_checksum = echo_csum;
      end
      EM_HELD: begin
        res_d.send_valid     = 1'b1;
        res_d.tx_flag        = held_flag_q;
        res_d.tx_index       = (held_flag_q == FL_DATA) ? seq_q : 16'd0;
        res_d.tx_filelen     = held_filelen_q;
        res_d.tx_checksum    = held_csum_q;
        res_d.payload_offset = (held_flag_q == FL_DATA) ? off_q : 32'd0;
        res_d.payload_len    = held_seg_len_q;
      end
      default: begin
      end
    endcase
    res_d.phase = phase_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q      <= TimeoutReset;
      phase_q        <= PH_CLOSED;
      seq_q          <= 16'd0;
      timer_q        <= 16'd0;
      left_q         <= 32'd0;
      off_q          <= 32'd0;
      held_flag_q    <= FL_DATA;
      held_filelen_q <= 32'd0;
      held_csum_q    <= 16'd0;
      held_seg_len_q <= 11'd0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_data_i;
      end
      phase_q        <= phase_d;
      seq_q          <= seq_d;
      timer_q        <= timer_d;
      left_q         <= left_d;
      off_q          <= off_d;
      held_flag_q    <= held_flag_d;
      held_filelen_q <= held_filelen_d;
      held_csum_q    <= held_csum_d;
      held_seg_len_q <= held_seg_len_d;
      out_valid_q    <= in_fire || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= res_d;
    end
  end

`include "stop_and_wait_sender_assert.svh"

  `SWS_ASSERT(a_phase_matches, out_valid_q, out_q.phase == phase_q, "Result phase differs from link phase")
  `SWS_ASSERT(a_idle_result_zero, out_valid_q && !out_q.send_valid, out_q.tx_flag == FL_DATA && out_q.payload_len == 11'd0 && out_q.tx_checksum == 16'd0, "Silent result carries header fields")
  `SWS_ASSERT(a_segment_len, out_valid_q && out_q.send_valid && out_q.tx_flag == FL_DATA, out_q.payload_len != 11'd0 && out_q.payload_len <= SegLen && out_q.tx_filelen == 32'(out_q.payload_len), "Data segment length out of range")
  `SWS_ASSERT_NEXT(a_open_sends_syn, in_fire && func == FN_OPEN && phase_q == PH_CLOSED, phase_q == PH_SYN_SENT && out_q.send_valid && out_q.tx_flag == FL_SYN, "Open from closed did not send SYN")

endmodule
